// ===== hw/rtl/sm4_pkg.sv =====
// ----------------------------------------------------------------------------
// SM4 shared definitions
// S-box, key constants, state and command types used by the SM4 engine.
// ----------------------------------------------------------------------------
package sm4_pkg;

  localparam int unsigned ROUNDS = 32;
  localparam int unsigned RND_W  = 5;

  localparam logic [2:0] REG_KEY0  = 3'd0;
  localparam logic [2:0] REG_KEY1  = 3'd1;
  localparam logic [2:0] REG_KEY2  = 3'd2;
  localparam logic [2:0] REG_KEY3  = 3'd3;
  localparam logic [2:0] REG_IV_HI = 3'd4;
  localparam logic [2:0] REG_IV_LO = 3'd5;
  localparam logic [2:0] REG_MODE  = 3'd6;

  localparam logic [31:0] FK0 = 32'hA3B1BAC6;
  localparam logic [31:0] FK1 = 32'h56AA3350;
  localparam logic [31:0] FK2 = 32'h677D9197;
  localparam logic [31:0] FK3 = 32'hB27022DC;

  localparam logic [63:0] PAD_FULL = 64'h1010101010101010;

  typedef enum logic [2:0] {
    ST_KEYGEN,
    ST_IDLE,
    ST_RUN,
    ST_OUT,
    ST_PAD_RUN,
    ST_PAD_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic key_start;   // load key schedule registers
    logic key_step;    // one key expansion round
    logic load_item;   // capture input item and start rounds
    logic load_pad;    // start the extra full-pad block
    logic round_step;  // one cipher round
    logic finish;      // form the output from the round state
    logic last_flag;   // last_result for the result being formed
  } sm4_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rounds_done;
    logic need_pad;
  } sm4_stat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] sub_word(input logic [31:0] a);
    return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // CK word: byte j is ((4i + j) * 7) mod 256
  function automatic logic [31:0] ck_word(input logic [RND_W-1:0] i);
    logic [7:0] b0;
    b0 = 8'({i, 2'b00}) * 8'd7;
    return {b0, b0 + 8'd7, b0 + 8'd14, b0 + 8'd21};
  endfunction

endpackage

// ===== hw/rtl/sm4_ctrl.sv =====
// ----------------------------------------------------------------------------
// SM4 controller
// Sequences key expansion, cipher rounds, the extra pad block and output.
// ----------------------------------------------------------------------------
module sm4_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              key_write,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sm4_pkg::sm4_stat_t stat,
  output sm4_pkg::sm4_cmd_t  cmd,
  output logic              idle
);
  import sm4_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_KEYGEN;
    else     state <= state_next;
  end

  logic key_pend, key_pend_next;
  always_ff @(posedge clk) begin
    if (rst) key_pend <= 1'b0;
    else     key_pend <= key_pend_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    key_pend_next = key_pend | key_write;
    idle = (state == ST_IDLE);
    unique case (state)
      ST_KEYGEN: begin
        cmd.key_step = 1'b1;
        if (stat.rounds_done) begin
          cmd.key_step = 1'b0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (key_pend) begin
          cmd.key_start = 1'b1;
          key_pend_next = key_write;
          state_next = ST_KEYGEN;
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.load_item = 1'b1;
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd.round_step = 1'b1;
        if (stat.rounds_done) begin
          cmd.round_step = 1'b0;
          cmd.finish = 1'b1;
          cmd.last_flag = !stat.need_pad;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.need_pad) begin
            cmd.load_pad = 1'b1;
            state_next = ST_PAD_RUN;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PAD_RUN: begin
        cmd.round_step = 1'b1;
        if (stat.rounds_done) begin
          cmd.round_step = 1'b0;
          cmd.finish = 1'b1;
          cmd.last_flag = 1'b1;
          state_next = ST_PAD_OUT;
        end
      end
      ST_PAD_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    if (key_write && state == ST_KEYGEN) key_pend_next = 1'b1;
  end

endmodule

// ===== hw/rtl/sm4_dpath.sv =====
// ----------------------------------------------------------------------------
// SM4 datapath
// Key schedule, one shared round unit, chaining, padding and pad check.
// ----------------------------------------------------------------------------
module sm4_dpath (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        key_word [4],
  input  logic [63:0]        iv_hi,
  input  logic [63:0]        iv_lo,
  input  logic               chain_mode,
  input  logic               op,
  input  logic               first_block,
  input  logic               last_block,
  input  logic [4:0]         valid_bytes,
  input  logic [63:0]        data_hi,
  input  logic [63:0]        data_lo,
  input  sm4_pkg::sm4_cmd_t  cmd,
  output sm4_pkg::sm4_stat_t stat,
  output logic [63:0]        result_hi,
  output logic [63:0]        result_lo,
  output logic [4:0]         kept_bytes,
  output logic               pad_error,
  output logic               last_result
);
  import sm4_pkg::*;

  logic [31:0]      rk [ROUNDS];
  logic [31:0]      kx [4];
  logic [31:0]      x  [4];
  logic [RND_W-1:0] cnt;
  logic             cnt_wrap;
  logic [63:0]      chain_hi, chain_lo;
  logic [63:0]      cin_hi, cin_lo;
  logic             dec, last, need_pad;

  // key schedule round
  logic [31:0] kt, knew;
  assign kt   = sub_word(kx[1] ^ kx[2] ^ kx[3] ^ ck_word(cnt));
  assign knew = kx[0] ^ kt ^ rotl(kt, 13) ^ rotl(kt, 23);

  // cipher round
  logic [31:0]      rkey, bt, xnew;
  logic [RND_W-1:0] ridx;
  assign ridx = dec ? ~cnt : cnt;
  assign rkey = rk[ridx];
  assign bt   = sub_word(x[1] ^ x[2] ^ x[3] ^ rkey);
  assign xnew = x[0] ^ bt ^ rotl(bt, 2) ^ rotl(bt, 10) ^ rotl(bt, 18) ^ rotl(bt, 24);

  assign stat.rounds_done = cnt_wrap;
  assign stat.need_pad    = need_pad;

  // input padding and chaining
  logic [4:0]   vsat;
  logic [127:0] blk_in, padded;
  logic [63:0]  ch_hi_sel, ch_lo_sel;
  always_comb begin
    vsat = (valid_bytes > 5'd16) ? 5'd16 : valid_bytes;
    blk_in = {data_hi, data_lo};
    padded = blk_in;
    if (!op && last_block && vsat != 5'd16) begin
      for (int i = 0; i < 16; i++) begin
        if (5'(i) >= vsat) padded[127 - 8*i -: 8] = 8'(5'd16 - vsat);
      end
    end
    ch_hi_sel = first_block ? iv_hi : chain_hi;
    ch_lo_sel = first_block ? iv_lo : chain_lo;
    if (!op && chain_mode) padded = padded ^ {ch_hi_sel, ch_lo_sel};
  end

  // output: reversed words, decrypt unchain, pad check
  logic [127:0] ct, pt;
  logic [7:0]   pad;
  logic         bad;
  always_comb begin
    ct = {x[3], x[2], x[1], x[0]};
    pt = (dec && chain_mode) ? (ct ^ {cin_hi, cin_lo}) : ct;
    pad = pt[7:0];
    bad = (pad == 8'd0) || (pad > 8'd16);
    for (int i = 0; i < 16; i++) begin
      if (8'(16 - i) <= pad && pt[127 - 8*i -: 8] != pad) bad = 1'b1;
    end
  end

  // original ciphertext for decrypt chaining
  logic [63:0] din_hi, din_lo;
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      din_hi <= data_hi;
      din_lo <= data_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      cnt_wrap <= 1'b0;
      chain_hi <= '0;
      chain_lo <= '0;
      // key registers reset to the zero key xor FK, so the first expansion runs on the zero key
      kx[0] <= FK0;
      kx[1] <= FK1;
      kx[2] <= FK2;
      kx[3] <= FK3;
    end else begin
      cnt_wrap <= 1'b0;
      if (cmd.key_start) begin
        kx[0] <= key_word[0] ^ FK0;
        kx[1] <= key_word[1] ^ FK1;
        kx[2] <= key_word[2] ^ FK2;
        kx[3] <= key_word[3] ^ FK3;
        cnt   <= '0;
      end else if (cmd.key_step) begin
        rk[cnt] <= knew;
        kx[0] <= kx[1]; kx[1] <= kx[2]; kx[2] <= kx[3]; kx[3] <= knew;
        cnt <= cnt + 1'b1;
        cnt_wrap <= (cnt == RND_W'(ROUNDS - 1));
      end
      if (cmd.load_item) begin
        x[0] <= padded[127:96]; x[1] <= padded[95:64];
        x[2] <= padded[63:32];  x[3] <= padded[31:0];
        dec  <= op;
        last <= last_block;
        need_pad <= !op && last_block && vsat == 5'd16;
        cin_hi <= ch_hi_sel;
        cin_lo <= ch_lo_sel;
        cnt <= '0;
      end
      if (cmd.load_pad) begin
        x[0] <= PAD_FULL[63:32] ^ (chain_mode ? chain_hi[63:32] : 32'd0);
        x[1] <= PAD_FULL[31:0]  ^ (chain_mode ? chain_hi[31:0]  : 32'd0);
        x[2] <= PAD_FULL[63:32] ^ (chain_mode ? chain_lo[63:32] : 32'd0);
        x[3] <= PAD_FULL[31:0]  ^ (chain_mode ? chain_lo[31:0]  : 32'd0);
        need_pad <= 1'b0;
        cnt <= '0;
      end
      if (cmd.round_step) begin
        x[0] <= x[1]; x[1] <= x[2]; x[2] <= x[3]; x[3] <= xnew;
        cnt <= cnt + 1'b1;
        cnt_wrap <= (cnt == RND_W'(ROUNDS - 1));
      end
      if (cmd.finish) begin
        result_hi   <= pt[127:64];
        result_lo   <= pt[63:0];
        last_result <= cmd.last_flag;
        if (dec && last) begin
          pad_error  <= bad;
          kept_bytes <= bad ? 5'd0 : 5'(5'd16 - pad[4:0]);
        end else begin
          pad_error  <= 1'b0;
          kept_bytes <= 5'd16;
        end
        if (chain_mode) begin
          if (dec) begin
            chain_hi <= din_hi;
            chain_lo <= din_lo;
          end else begin
            chain_hi <= ct[127:64];
            chain_lo <= ct[63:0];
          end
        end
      end else if (cmd.load_item && first_block) begin
        chain_hi <= iv_hi;
        chain_lo <= iv_lo;
      end
    end
  end

endmodule

// ===== hw/rtl/sm4_block_cipher_ecb_cbc.sv =====
// ----------------------------------------------------------------------------
// SM4 block cipher, ECB/CBC with PKCS#7 padding
// Top level: stream ports, configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// A block is loaded on its input transfer, runs 32 rounds through the shared
// round unit, then its result is formed and held until its output transfer;
// only then is the next input taken. A full final encrypt block adds a second
// pass for the added pad block. A key word write starts, once the engine is
// idle, a 32-round key expansion that keeps the input closed (after reset,
// the expansion of the zero key runs once).
module sm4_block_cipher_ecb_cbc (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,   // valid_bytes[4:0], data_hi[68:5], data_lo[132:69], zero
  input  logic         s_tlast,   // last_block
  input  logic [1:0]   s_tuser,   // op[0], first_block[1]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // result_hi[63:0], result_lo[127:64], kept_bytes[132:128], zero
  output logic         m_tlast,   // last_result
  output logic         m_tuser,   // pad_error
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  import sm4_pkg::*;

  logic [31:0] key_word [4];
  logic [63:0] iv_hi, iv_lo;
  logic        chain_mode;
  logic        cfg_we, key_write, idle;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign key_write = cfg_we && (cfg_index == REG_KEY0 || cfg_index == REG_KEY1 ||
                                cfg_index == REG_KEY2 || cfg_index == REG_KEY3);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key_word[i] <= '0;
      iv_hi <= '0;
      iv_lo <= '0;
      chain_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY0:  key_word[0] <= cfg_data[31:0];
        REG_KEY1:  key_word[1] <= cfg_data[31:0];
        REG_KEY2:  key_word[2] <= cfg_data[31:0];
        REG_KEY3:  key_word[3] <= cfg_data[31:0];
        REG_IV_HI: iv_hi <= cfg_data;
        REG_IV_LO: iv_lo <= cfg_data;
        REG_MODE:  chain_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sm4_cmd_t  cmd;
  sm4_stat_t stat;
  logic [63:0] result_hi, result_lo;
  logic [4:0]  kept_bytes;

  sm4_ctrl u_ctrl (
    .clk, .rst, .key_write,
    .in_valid (s_tvalid), .in_ready (s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .stat, .cmd, .idle
  );

  sm4_dpath u_dpath (
    .clk, .rst, .key_word, .iv_hi, .iv_lo, .chain_mode,
    .op(s_tuser[0]), .first_block(s_tuser[1]), .last_block(s_tlast),
    .valid_bytes(s_tdata[4:0]), .data_hi(s_tdata[68:5]), .data_lo(s_tdata[132:69]),
    .cmd, .stat, .result_hi, .result_lo, .kept_bytes,
    .pad_error(m_tuser), .last_result(m_tlast)
  );

  assign m_tdata = {3'b000, kept_bytes, result_lo, result_hi};

  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input taken while result pending");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> idle) else $error("input ready outside idle");
  a_pad_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && kept_bytes == 5'd0)
    else $error("pad error on non-final result");
  a_kept_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> kept_bytes <= 5'd16) else $error("kept_bytes out of range");

endmodule

// ===== sim/sm4_block_cipher_ecb_cbc_test.sv =====
// ----------------------------------------------------------------------------
// SM4 ECB/CBC engine testbench
// Drives single blocks and short messages with random spacing on both stream
// sides, predicts every output block with a behavioral SM4 model that carries
// its own key schedule and chaining value, and compares field by field.
// ----------------------------------------------------------------------------
module sm4_block_cipher_ecb_cbc_test;
  import sm4_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  kept;
    logic        err;
    logic        last;
  } block_res_t;

  typedef struct {
    logic        dec;
    logic        first;
    logic        last;
    logic [4:0]  nbytes;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        has_exp;
    block_res_t  exp_res;
  } blk_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;
  logic         m_tlast;
  logic         m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  sm4_block_cipher_ecb_cbc dut (.*);

  always #4 clk = ~clk;

  // predictor state
  logic [31:0] key_w [4];
  logic [63:0] iv_h, iv_l;
  logic        cbc_on;
  logic [31:0] rkeys [32];
  logic [63:0] chain_h, chain_l;

  block_res_t  expected_blocks [$];
  int          mismatches = 0;
  bit          rx_stall_on = 1'b1;

  function automatic logic [31:0] sb_word(logic [31:0] a);
    return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
  endfunction

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic expand_schedule();
    logic [31:0] k [4];
    logic [31:0] t, ck;
    k[0] = key_w[0] ^ FK0; k[1] = key_w[1] ^ FK1;
    k[2] = key_w[2] ^ FK2; k[3] = key_w[3] ^ FK3;
    for (int i = 0; i < 32; i++) begin
      for (int j = 0; j < 4; j++) ck[31-8*j -: 8] = 8'((4*i + j) * 7);
      t = sb_word(k[1] ^ k[2] ^ k[3] ^ ck);
      rkeys[i] = k[0] ^ t ^ rol(t, 13) ^ rol(t, 23);
      k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = rkeys[i];
    end
  endtask

  function automatic logic [127:0] sm4_core(logic [127:0] blk, logic dec);
    logic [31:0] x [4];
    logic [31:0] b, nx;
    x[0] = blk[127:96]; x[1] = blk[95:64]; x[2] = blk[63:32]; x[3] = blk[31:0];
    for (int i = 0; i < 32; i++) begin
      b = sb_word(x[1] ^ x[2] ^ x[3] ^ rkeys[dec ? 31 - i : i]);
      nx = x[0] ^ b ^ rol(b, 2) ^ rol(b, 10) ^ rol(b, 18) ^ rol(b, 24);
      x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nx;
    end
    return {x[3], x[2], x[1], x[0]};
  endfunction

  function automatic logic [127:0] encrypt_chained(logic [127:0] blk);
    logic [127:0] c;
    if (cbc_on) blk ^= {chain_h, chain_l};
    c = sm4_core(blk, 1'b0);
    if (cbc_on) {chain_h, chain_l} = c;
    return c;
  endfunction

  task automatic apply_reg(logic [2:0] idx, logic [63:0] val);
    case (idx)
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
        key_w[idx[1:0]] = val[31:0];
        expand_schedule();
      end
      REG_IV_HI: iv_h = val;
      REG_IV_LO: iv_l = val;
      REG_MODE:  cbc_on = val[0];
      default: ;
    endcase
  endtask

  // work out results of one block and queue them
  task automatic predict_block(logic dec, logic first, logic last, logic [4:0] nb,
                               logic [63:0] hi, logic [63:0] lo);
    logic [127:0] blk, r;
    int vb, pad;
    logic bad;
    block_res_t e;
    blk = {hi, lo};
    vb = (nb > 16) ? 16 : nb;
    if (first) {chain_h, chain_l} = {iv_h, iv_l};
    if (!dec) begin
      if (last && vb < 16)
        for (int i = vb; i < 16; i++) blk[127-8*i -: 8] = 8'(16 - vb);
      r = encrypt_chained(blk);
      e = '{r[127:64], r[63:0], 5'd16, 1'b0, 1'b1};
      if (last && vb == 16) begin
        e.last = 1'b0;
        expected_blocks.push_back(e);
        r = encrypt_chained({PAD_FULL, PAD_FULL});
        e = '{r[127:64], r[63:0], 5'd16, 1'b0, 1'b1};
      end
      expected_blocks.push_back(e);
    end else begin
      r = sm4_core(blk, 1'b1);
      if (cbc_on) begin
        r ^= {chain_h, chain_l};
        {chain_h, chain_l} = blk;
      end
      e = '{r[127:64], r[63:0], 5'd16, 1'b0, 1'b1};
      if (last) begin
        pad = r[7:0];
        bad = (pad == 0 || pad > 16);
        if (!bad)
          for (int i = 16 - pad; i < 16; i++)
            if (r[127-8*i -: 8] != pad) bad = 1'b1;
        e.kept = bad ? 5'd0 : 5'(16 - pad);
        e.err = bad;
      end
      expected_blocks.push_back(e);
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // output side: random stall, compare each transfer
  initial begin
    int g;
    block_res_t got, want;
    @(posedge clk iff !rst);
    forever begin
      g = rx_stall_on ? gap_len() : 0;
      if (g > 0) begin
        m_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk iff m_tvalid);
      got = '{m_tdata[63:0], m_tdata[127:64], m_tdata[132:128], m_tuser, m_tlast};
      if (expected_blocks.size() == 0) begin
        report_mismatch("unexpected transfer", got.hi, '0);
      end else begin
        want = expected_blocks.pop_front();
        if (got.hi !== want.hi) report_mismatch("result_hi", got.hi, want.hi);
        if (got.lo !== want.lo) report_mismatch("result_lo", got.lo, want.lo);
        if (got.kept !== want.kept) report_mismatch("kept_bytes", got.kept, want.kept);
        if (got.err !== want.err) report_mismatch("pad_error", got.err, want.err);
        if (got.last !== want.last) report_mismatch("last_result", got.last, want.last);
      end
    end
  end

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk iff cfg_ready);
    apply_reg(idx, val);
  endtask

  task automatic send_block(logic dec, logic first, logic last, logic [4:0] nb,
                            logic [63:0] hi, logic [63:0] lo);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, lo, hi, nb};
    s_tlast  <= last;
    s_tuser  <= {first, dec};
    @(posedge clk iff s_tready);
    predict_block(dec, first, last, nb, hi, lo);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    wait (expected_blocks.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  // random setting, extremes mixed in
  task automatic reprogram(bit extreme_lo, bit extreme_hi, logic mode);
    logic [63:0] v;
    for (int i = 0; i < 6; i++) begin
      v = {$urandom, $urandom};
      if (extreme_lo) v = '0;
      if (extreme_hi) v = '1;
      write_reg(3'(i), v);
    end
    write_reg(REG_MODE, {63'd0, mode});
    cfg_valid <= 1'b0;
  endtask

  // a pad block built so that a decrypt sees a chosen plaintext tail
  function automatic logic [127:0] plain_tail(int pad, bit corrupt);
    logic [127:0] p;
    p = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 16 - pad; i < 16; i++) p[127-8*i -: 8] = 8'(pad);
    if (corrupt) p[127-8*(16 - pad) -: 8] ^= 8'h01;
    return p;
  endfunction

  blk_row_t dir_rows [$];

  initial begin
    blk_row_t row;
    logic [127:0] p, c;
    int n, nb, kind;
    logic dec, mode;
    key_w = '{default: '0};
    iv_h = '0; iv_l = '0; cbc_on = 1'b0; chain_h = '0; chain_l = '0;
    expand_schedule();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: ECB under the reset key, then extremes
    dir_rows.push_back('{1'b0, 1'b0, 1'b0, 5'd0, '0, '0, 1'b0, '0});
    dir_rows.push_back('{1'b0, 1'b0, 1'b0, 5'd31, '1, '1, 1'b0, '0});
    dir_rows.push_back('{1'b1, 1'b0, 1'b0, 5'd0, '0, '0, 1'b0, '0});
    dir_rows.push_back('{1'b1, 1'b1, 1'b1, 5'd0, '1, '1, 1'b0, '0});
    dir_rows.push_back('{1'b0, 1'b1, 1'b1, 5'd0, 64'h0123456789abcdef,
                         64'hfedcba9876543210, 1'b0, '0});
    dir_rows.push_back('{1'b0, 1'b0, 1'b1, 5'd7, '1, '1, 1'b0, '0});
    dir_rows.push_back('{1'b0, 1'b0, 1'b1, 5'd15, '0, '1, 1'b0, '0});
    dir_rows.push_back('{1'b0, 1'b0, 1'b1, 5'd16, '1, '0, 1'b0, '0});
    dir_rows.push_back('{1'b0, 1'b0, 1'b1, 5'd20, '1, '1, 1'b0, '0});
    dir_rows.push_back('{1'b0, 1'b1, 1'b0, 5'd1, 64'haaaaaaaaaaaaaaaa,
                         64'h5555555555555555, 1'b0, '0});
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_block(row.dec, row.first, row.last, row.nbytes, row.hi, row.lo);
    end
    drain();

    // decrypt padding cases: good pads 1, 9 and 16, zero pad, pad 17, broken run
    reprogram(1'b0, 1'b0, 1'b0);
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: p = plain_tail(1, 1'b0);
        1: p = plain_tail(16, 1'b0);
        2: p = plain_tail(5, 1'b1);
        3: begin p = plain_tail(1, 1'b0); p[7:0] = 8'd0; end
        4: begin p = plain_tail(1, 1'b0); p[7:0] = 8'd17; end
        default: p = plain_tail(9, 1'b0);
      endcase
      c = sm4_core(p, 1'b0);
      send_block(1'b1, 1'b0, 1'b1, 5'($urandom_range(0, 31)), c[127:64], c[63:0]);
    end
    drain();

    // random phases: well-formed messages, round-tripped decrypts and noise
    n = 0;
    for (int ph = 0; n < 1020; ph++) begin
      mode = (ph % 3 != 2);
      reprogram(ph == 1, ph == 2, mode);
      if (ph == 4) rx_stall_on = 1'b0;
      if (ph == 5) rx_stall_on = 1'b1;
      for (int m = 0; m < 25 && n < 1020; m++) begin
        kind = $urandom_range(0, 9);
        dec = kind >= 6;
        if (kind == 9) begin
          send_block(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)),
                     5'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
          n++;
        end else begin
          int len;
          len = $urandom_range(1, 4);
          for (int b = 0; b < len; b++) begin
            nb = ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(0, 31);
            if (dec && b == len - 1 && !cbc_on && $urandom_range(0, 1)) begin
              c = sm4_core(plain_tail($urandom_range(1, 16), $urandom_range(0, 3) == 0),
                           1'b0);
              send_block(1'b1, b == 0, 1'b1, 5'(nb), c[127:64], c[63:0]);
            end else begin
              send_block(dec, b == 0, b == len - 1, 5'(nb),
                         {$urandom, $urandom}, {$urandom, $urandom});
            end
            n++;
          end
        end
      end
      // hold off until every block is back before touching registers
      drain();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(20ms);
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sm4_pkg.sv
hw/rtl/sm4_ctrl.sv
hw/rtl/sm4_dpath.sv
hw/rtl/sm4_block_cipher_ecb_cbc.sv
sim/sm4_block_cipher_ecb_cbc_test.sv
